// ===== rtl/tcd_pkg.sv =====
package tcd_pkg;

    localparam int VC_W     = 7;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;
    localparam int STEP_W   = 5;

    localparam logic [VC_W-1:0] VC_RESET = 7'd2;
    localparam logic            REG_VERTEX_COUNT = 1'b0;

    localparam logic [1:0] MARK_WHITE = 2'd0;
    localparam logic [1:0] MARK_GREY  = 2'd1;
    localparam logic [1:0] MARK_BLACK = 2'd2;

    // branch conditions
    localparam logic [3:0] COND_NONE          = 4'd0;
    localparam logic [3:0] COND_ALWAYS        = 4'd1;
    localparam logic [3:0] COND_ROOT_NOT_LAST = 4'd2;
    localparam logic [3:0] COND_WHITE         = 4'd3;
    localparam logic [3:0] COND_DEPTH_ONE     = 4'd4;
    localparam logic [3:0] COND_CUR_END       = 4'd5;
    localparam logic [3:0] COND_NO_EDGE       = 4'd6;
    localparam logic [3:0] COND_GREY          = 4'd7;
    localparam logic [3:0] COND_NOT_PUSHABLE  = 4'd8;

    localparam logic [1:0] MA_ROOT = 2'd0;
    localparam logic [1:0] MA_C    = 2'd1;
    localparam logic [1:0] MA_V    = 2'd2;

    localparam logic CA_V = 1'b0;
    localparam logic CA_C = 1'b1;

    localparam logic CV_ZERO = 1'b0;
    localparam logic CV_NEXT = 1'b1;

    localparam logic [1:0] VS_HOLD  = 2'd0;
    localparam logic [1:0] VS_STACK = 2'd1;
    localparam logic [1:0] VS_C     = 2'd2;

    localparam logic [1:0] CS_HOLD = 2'd0;
    localparam logic [1:0] CS_ROOT = 2'd1;
    localparam logic [1:0] CS_CUR  = 2'd2;

    localparam logic [1:0] RO_HOLD = 2'd0;
    localparam logic [1:0] RO_ZERO = 2'd1;
    localparam logic [1:0] RO_INC  = 2'd2;

    localparam logic [1:0] DO_HOLD = 2'd0;
    localparam logic [1:0] DO_INC  = 2'd1;
    localparam logic [1:0] DO_DEC  = 2'd2;

    // program steps
    localparam logic [STEP_W-1:0] STEP_CLR   = 5'd0;
    localparam logic [STEP_W-1:0] STEP_RINIT = 5'd1;
    localparam logic [STEP_W-1:0] STEP_RSEL  = 5'd2;
    localparam logic [STEP_W-1:0] STEP_RMRK  = 5'd3;
    localparam logic [STEP_W-1:0] STEP_RTST  = 5'd4;
    localparam logic [STEP_W-1:0] STEP_RNEXT = 5'd5;
    localparam logic [STEP_W-1:0] STEP_ACYC  = 5'd6;
    localparam logic [STEP_W-1:0] STEP_POP   = 5'd7;
    localparam logic [STEP_W-1:0] STEP_TOPRD = 5'd8;
    localparam logic [STEP_W-1:0] STEP_TOPGT = 5'd9;
    localparam logic [STEP_W-1:0] STEP_CURRD = 5'd10;
    localparam logic [STEP_W-1:0] STEP_CURGT = 5'd11;
    localparam logic [STEP_W-1:0] STEP_ADJRD = 5'd12;
    localparam logic [STEP_W-1:0] STEP_ADJGT = 5'd13;
    localparam logic [STEP_W-1:0] STEP_MRKRD = 5'd14;
    localparam logic [STEP_W-1:0] STEP_MRKGT = 5'd15;
    localparam logic [STEP_W-1:0] STEP_MRKTS = 5'd16;
    localparam logic [STEP_W-1:0] STEP_PUSH  = 5'd17;
    localparam logic [STEP_W-1:0] STEP_CYC   = 5'd18;

    typedef struct packed {
        logic [3:0]        cond;
        logic [STEP_W-1:0] target;
        logic              mark_we;
        logic              mark_re;
        logic [1:0]        mark_asel;
        logic [1:0]        mark_val;
        logic              cur_we;
        logic              cur_re;
        logic              cur_asel;
        logic              cur_val;
        logic              stk_we;
        logic              stk_re;
        logic              adj_re;
        logic [1:0]        root_op;
        logic [1:0]        depth_op;
        logic [1:0]        v_src;
        logic [1:0]        c_src;
        logic              done;
        logic              result;
    } t_uword;

    typedef struct packed {
        logic start;
        logic hold;
    } t_dfs_cmd;

    typedef struct packed {
        logic done;
        logic acyclic;
    } t_dfs_status;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '0;
        case (step)
            STEP_CLR: begin
                w.mark_we   = 1'b1;
                w.mark_asel = MA_ROOT;
                w.mark_val  = MARK_WHITE;
                w.root_op   = RO_INC;
                w.cond      = COND_ROOT_NOT_LAST;
                w.target    = STEP_CLR;
            end
            STEP_RINIT: begin
                w.root_op = RO_ZERO;
            end
            STEP_RSEL: begin
                w.c_src = CS_ROOT;
            end
            STEP_RMRK: begin
                w.mark_re   = 1'b1;
                w.mark_asel = MA_C;
            end
            STEP_RTST: begin
                w.cond   = COND_WHITE;
                w.target = STEP_PUSH;
            end
            STEP_RNEXT: begin
                w.root_op = RO_INC;
                w.cond    = COND_ROOT_NOT_LAST;
                w.target  = STEP_RSEL;
            end
            STEP_ACYC: begin
                w.done   = 1'b1;
                w.result = 1'b1;
            end
            STEP_POP: begin
                w.mark_we   = 1'b1;
                w.mark_asel = MA_V;
                w.mark_val  = MARK_BLACK;
                w.depth_op  = DO_DEC;
                w.cond      = COND_DEPTH_ONE;
                w.target    = STEP_RNEXT;
            end
            STEP_TOPRD: begin
                w.stk_re = 1'b1;
            end
            STEP_TOPGT: begin
                w.v_src = VS_STACK;
            end
            STEP_CURRD: begin
                w.cur_re   = 1'b1;
                w.cur_asel = CA_V;
            end
            STEP_CURGT: begin
                w.c_src  = CS_CUR;
                w.cond   = COND_CUR_END;
                w.target = STEP_POP;
            end
            STEP_ADJRD: begin
                w.cur_we   = 1'b1;
                w.cur_asel = CA_V;
                w.cur_val  = CV_NEXT;
                w.adj_re   = 1'b1;
            end
            STEP_ADJGT: begin
                w.cond   = COND_NO_EDGE;
                w.target = STEP_CURRD;
            end
            STEP_MRKRD: begin
                w.mark_re   = 1'b1;
                w.mark_asel = MA_C;
            end
            STEP_MRKGT: begin
                w.cond   = COND_GREY;
                w.target = STEP_CYC;
            end
            STEP_MRKTS: begin
                w.cond   = COND_NOT_PUSHABLE;
                w.target = STEP_CURRD;
            end
            STEP_PUSH: begin
                w.mark_we   = 1'b1;
                w.mark_asel = MA_C;
                w.mark_val  = MARK_GREY;
                w.cur_we    = 1'b1;
                w.cur_asel  = CA_C;
                w.cur_val   = CV_ZERO;
                w.stk_we    = 1'b1;
                w.depth_op  = DO_INC;
                w.v_src     = VS_C;
                w.cond      = COND_ALWAYS;
                w.target    = STEP_CURRD;
            end
            STEP_CYC: begin
                w.done   = 1'b1;
                w.result = 1'b0;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_CLR;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/tcd_edge_if.sv =====
interface tcd_edge_if;
    logic valid;
    logic ready;
    logic edge_blue;

    modport source(output valid, output edge_blue, input ready);
    modport sink(input valid, input edge_blue, output ready);
endinterface

// ===== rtl/tcd_result_if.sv =====
interface tcd_result_if;
    logic valid;
    logic ready;
    logic acyclic;

    modport source(output valid, output acyclic, input ready);
    modport sink(input valid, input acyclic, output ready);
endinterface

// ===== rtl/tournament_cycle_detector_unit.sv =====
// Tournament cycle detector.
// i_edge (sink): one colour bit per vertex pair (i<j), row-major over the
//   upper triangle; 1 orients the edge i->j, 0 orients it j->i.
// o_result (source): one request per complete graph, acyclic = 1 when the
//   oriented graph has no directed cycle.
// APB port: register 0 is vertex_count (7 bits, read back as written, used
//   clamped to 2..MAX_VERTICES); a write restarts loading at pair (0,1).
// Throughput: one pair per cycle while loading. After the last pair the
//   input stalls while a microcoded depth-first search walks the matrix:
//   it clears the mark of every vertex in use, then for each root selects it and tests its
//   mark; each neighbour test reads the cursor and the adjacency row, a
//   found edge has the neighbour's mark read and tested before a push,
//   and a pop marks the vertex black and reloads the stack top. The
//   result is registered in the cycle after the final step.
// Reset: vertex_count = 2, loading at pair (0,1), no result pending.
// Stall: the result register holds until taken; pairs of the next graph
//   are still accepted, and a finished search waits on its last step.
module tournament_cycle_detector_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tcd_edge_if.sink                     i_edge,
    tcd_result_if.source                 o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcd_pkg::ADDR_W-1:0]   paddr,
    input  logic [tcd_pkg::DATA_W-1:0]   pwdata,
    output logic [tcd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import tcd_pkg::*;

    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int IW   = $clog2(MAX_VERTICES);
    localparam int CMPW = (CW > VC_W) ? CW : VC_W;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    logic            r_mode, n_mode;
    logic [VC_W-1:0] r_vc, n_vc;
    logic [CW-1:0]   r_n, n_n;
    logic [IW-1:0]   r_lrow, n_lrow;
    logic [IW-1:0]   r_lcol, n_lcol;
    logic            r_out_valid, n_out_valid;
    logic            r_acyclic, n_acyclic;
    logic [MAX_VERTICES-1:0] r_row_buf, n_row_buf;

    logic            cfg_wr;
    logic [CMPW-1:0] vc_ext;
    logic [CW-1:0]   n_clamped;
    logic [IW-1:0]   nm1;
    logic [IW-1:0]   nm2;
    logic            acc;
    logic            row_end;
    logic            last_pair;

    t_dfs_cmd    dfs_cmd;
    t_dfs_status dfs_st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[ADDR_W-1] == REG_VERTEX_COUNT);
    assign prdata = (paddr[ADDR_W-1] == REG_VERTEX_COUNT) ?
                    DATA_W'(r_vc) : '0;

    always_comb begin
        vc_ext = CMPW'(pwdata[VC_W-1:0]);
        if (vc_ext < CMPW'(2)) begin
            n_clamped = CW'(2);
        end else if (vc_ext > CMPW'(MAX_VERTICES)) begin
            n_clamped = CW'(MAX_VERTICES);
        end else begin
            n_clamped = vc_ext[CW-1:0];
        end
    end

    assign nm1       = IW'(r_n - CW'(1));
    assign nm2       = IW'(r_n - CW'(2));
    assign i_edge.ready = (r_mode == MODE_LOAD);
    assign acc       = i_edge.valid && i_edge.ready;
    assign row_end   = (r_lcol == nm1);
    assign last_pair = row_end && (r_lrow == nm2);

    always_comb begin
        n_row_buf = r_row_buf;
        n_row_buf[r_lcol] = i_edge.edge_blue;
    end

    always_comb begin
        n_vc   = r_vc;
        n_n    = r_n;
        n_lrow = r_lrow;
        n_lcol = r_lcol;
        n_mode = r_mode;
        if (cfg_wr) begin
            n_vc   = pwdata[VC_W-1:0];
            n_n    = n_clamped;
            n_lrow = '0;
            n_lcol = IW'(1);
        end else if (acc) begin
            if (last_pair) begin
                n_lrow = '0;
                n_lcol = IW'(1);
                n_mode = MODE_SEARCH;
            end else if (row_end) begin
                n_lrow = IW'(r_lrow + IW'(1));
                n_lcol = IW'(r_lrow + IW'(2));
            end else begin
                n_lcol = IW'(r_lcol + IW'(1));
            end
        end
        if (dfs_st.done) begin
            n_mode = MODE_LOAD;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_acyclic   = r_acyclic;
        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        if (dfs_st.done) begin
            n_out_valid = 1'b1;
            n_acyclic   = dfs_st.acyclic;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LOAD;
            r_vc        <= VC_RESET;
            r_n         <= CW'(2);
            r_lrow      <= '0;
            r_lcol      <= IW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_vc        <= n_vc;
            r_n         <= n_n;
            r_lrow      <= n_lrow;
            r_lcol      <= n_lcol;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acyclic <= n_acyclic;
        if (acc) begin
            r_row_buf <= n_row_buf;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.acyclic = r_acyclic;

    assign dfs_cmd.start = acc && last_pair;
    assign dfs_cmd.hold  = r_out_valid && !o_result.ready;

    tcd_dfs #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_dfs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dfs_cmd),
        .i_n         (r_n),
        .i_adj_we    (acc && row_end),
        .i_adj_waddr (r_lrow),
        .i_adj_wdata (n_row_buf),
        .o_status    (dfs_st)
    );

    a_load_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_LOAD |-> r_lcol > r_lrow)
        else $error("load column not above load row");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dfs_st.done |-> (!r_out_valid || o_result.ready))
        else $error("result overwrites a pending request");

    a_search_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && last_pair) |=> (r_mode == MODE_SEARCH))
        else $error("search did not start after last pair");

endmodule

// ===== rtl/tcd_dfs.sv =====
module tcd_dfs #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tcd_pkg::t_dfs_cmd                     i_cmd,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]     i_n,
    input  logic                                  i_adj_we,
    input  logic [$clog2(MAX_VERTICES)-1:0]       i_adj_waddr,
    input  logic [MAX_VERTICES-1:0]               i_adj_wdata,
    output tcd_pkg::t_dfs_status                  o_status
);
    import tcd_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int IW = $clog2(MAX_VERTICES);

    // row lo holds bit hi = 1 when edge lo->hi, 0 when hi->lo
    logic [MAX_VERTICES-1:0] r_adj_mem [MAX_VERTICES];
    logic [1:0]              r_mark_mem [MAX_VERTICES];
    logic [CW-1:0]           r_cur_mem [MAX_VERTICES];
    logic [IW-1:0]           r_stk_mem [MAX_VERTICES];

    logic [MAX_VERTICES-1:0] r_adj_rd;
    logic [1:0]              r_mark_rd;
    logic [CW-1:0]           r_cur_rd;
    logic [IW-1:0]           r_stk_rd;

    logic              r_run, n_run;
    logic [STEP_W-1:0] r_pc, n_pc;
    logic [IW-1:0]     r_root, n_root;
    logic [CW-1:0]     r_depth, n_depth;
    logic [IW-1:0]     r_v, n_v;
    logic [CW-1:0]     r_c, n_c;

    t_uword        uw;
    logic [IW-1:0] nm1;
    logic [IW-1:0] c_idx;
    logic [IW-1:0] hi_idx;
    logic [IW-1:0] lo_idx;
    logic          v_lt_c;
    logic          has_edge;
    logic          take;
    logic [IW-1:0] mark_addr;
    logic [IW-1:0] cur_addr;
    logic [CW-1:0] cur_wdata;
    logic          act;

    assign uw     = ucode(r_pc);
    assign act    = r_run;
    assign nm1    = IW'(i_n - CW'(1));
    assign c_idx  = r_c[IW-1:0];
    assign v_lt_c = r_v < c_idx;
    assign hi_idx = v_lt_c ? c_idx : r_v;
    assign lo_idx = v_lt_c ? r_v : c_idx;

    always_comb begin
        if (r_v == c_idx) begin
            has_edge = 1'b0;
        end else if (v_lt_c) begin
            has_edge = r_adj_rd[hi_idx];
        end else begin
            has_edge = ~r_adj_rd[hi_idx];
        end
    end

    always_comb begin
        case (uw.mark_asel)
            MA_ROOT: mark_addr = r_root;
            MA_C:    mark_addr = c_idx;
            MA_V:    mark_addr = r_v;
            default: mark_addr = r_v;
        endcase
        cur_addr  = (uw.cur_asel == CA_C) ? c_idx : r_v;
        cur_wdata = (uw.cur_val == CV_NEXT) ? CW'(r_c + CW'(1)) : '0;
    end

    always_comb begin
        case (uw.cond)
            COND_NONE:          take = 1'b0;
            COND_ALWAYS:        take = 1'b1;
            COND_ROOT_NOT_LAST: take = r_root != nm1;
            COND_WHITE:         take = r_mark_rd == MARK_WHITE;
            COND_DEPTH_ONE:     take = r_depth == CW'(1);
            COND_CUR_END:       take = r_cur_rd >= i_n;
            COND_NO_EDGE:       take = ~has_edge;
            COND_GREY:          take = r_mark_rd == MARK_GREY;
            COND_NOT_PUSHABLE:  take = (r_mark_rd != MARK_WHITE) ||
                                       (r_depth == CW'(MAX_VERTICES));
            default:            take = 1'b0;
        endcase
    end

    always_comb begin
        n_run   = r_run;
        n_pc    = r_pc;
        n_root  = r_root;
        n_depth = r_depth;
        n_v     = r_v;
        n_c     = r_c;
        if (i_cmd.start) begin
            n_run   = 1'b1;
            n_pc    = STEP_CLR;
            n_root  = '0;
            n_depth = '0;
        end else if (act) begin
            if (uw.done) begin
                n_run = i_cmd.hold;
            end else begin
                n_pc = take ? uw.target : STEP_W'(r_pc + STEP_W'(1));
            end
            case (uw.root_op)
                RO_ZERO: n_root = '0;
                RO_INC:  n_root = IW'(r_root + IW'(1));
                default: n_root = r_root;
            endcase
            case (uw.depth_op)
                DO_INC:  n_depth = CW'(r_depth + CW'(1));
                DO_DEC:  n_depth = CW'(r_depth - CW'(1));
                default: n_depth = r_depth;
            endcase
            case (uw.v_src)
                VS_STACK: n_v = r_stk_rd;
                VS_C:     n_v = c_idx;
                default:  n_v = r_v;
            endcase
            case (uw.c_src)
                CS_ROOT: n_c = CW'(r_root);
                CS_CUR:  n_c = r_cur_rd;
                default: n_c = r_c;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_pc    <= STEP_CLR;
            r_root  <= '0;
            r_depth <= '0;
        end else begin
            r_run   <= n_run;
            r_pc    <= n_pc;
            r_root  <= n_root;
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_c <= n_c;
    end

    always_ff @(posedge i_clk) begin
        if (i_adj_we) begin
            r_adj_mem[i_adj_waddr] <= i_adj_wdata;
        end
        if (act && uw.adj_re) begin
            r_adj_rd <= r_adj_mem[lo_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (act && uw.mark_we) begin
            r_mark_mem[mark_addr] <= uw.mark_val;
        end
        if (act && uw.mark_re) begin
            r_mark_rd <= r_mark_mem[mark_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (act && uw.cur_we) begin
            r_cur_mem[cur_addr] <= cur_wdata;
        end
        if (act && uw.cur_re) begin
            r_cur_rd <= r_cur_mem[cur_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (act && uw.stk_we) begin
            r_stk_mem[r_depth[IW-1:0]] <= c_idx;
        end
        if (act && uw.stk_re) begin
            r_stk_rd <= r_stk_mem[IW'(r_depth - CW'(1))];
        end
    end

    assign o_status.done    = act && uw.done && !i_cmd.hold;
    assign o_status.acyclic = uw.result;

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> r_pc <= STEP_CYC)
        else $error("sequencer left the program");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> r_depth <= CW'(MAX_VERTICES))
        else $error("walk stack overflow");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status.done && !i_cmd.start) |=> !r_run)
        else $error("sequencer kept running after result");

endmodule

// ===== bench/tb_tournament_cycle_detector_unit.sv =====
module tb_tournament_cycle_detector_unit;
    import tcd_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 8;
    localparam int MAX_V          = 64;
    localparam int ITEM_GOAL      = 740;
    localparam int PRESSURE_HOLD  = 400;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int DIRECTED_LEN   = 33;

    localparam logic [ADDR_W-1:0] ADDR_VERTEX_COUNT = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;

    typedef enum logic [1:0] {
        ROW_PAIR,
        ROW_SET_REG,
        ROW_SET_UNMAPPED
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [DATA_W-1:0] value;
        logic              typed;
        logic              want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    tcd_edge_if   edge_ch();
    tcd_result_if res_ch();

    tournament_cycle_detector_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_edge   (edge_ch),
        .o_result (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // predictor state
    logic [VC_W-1:0] model_vc;
    logic [MAX_V-1:0] adj_rows [MAX_V];
    logic [5:0] fill_row;
    logic [6:0] fill_col;

    logic acyclic_q [$];
    t_stim_row directed_rows [DIRECTED_LEN];

    int unsigned error_count = 0;
    int unsigned pairs_sent = 0;
    int unsigned graphs_sent = 0;
    int unsigned acyclic_graphs = 0;
    int unsigned results_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned widest_graph = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    int unsigned rx_stall = 0;
    logic idle_enabled = 1'b1;
    logic last_completed = 1'b1;

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic int unsigned effective_vertices();
        int unsigned n;
        n = 32'(model_vc);
        if (n < 2) n = 2;
        if (n > MAX_V) n = MAX_V;
        return n;
    endfunction

    function automatic void clear_fill();
        for (int i = 0; i < MAX_V; i++) adj_rows[i] = '0;
        fill_row = '0;
        fill_col = 7'd1;
    endfunction

    // loads one pair; on the last pair runs the grey/black walk over the matrix
    function automatic void predict_pair(input logic blue, output logic complete,
                                         output logic acyclic);
        int unsigned n;
        int unsigned root;
        int unsigned depth;
        logic [1:0] colour [MAX_V];
        logic [5:0] trail [MAX_V];
        logic [6:0] probe [MAX_V];
        logic [5:0] v;
        logic [6:0] c;
        logic found;
        n = effective_vertices();
        if (fill_row >= n - 1 || fill_col >= n || fill_col <= {1'b0, fill_row}) begin
            fill_row = '0;
            fill_col = 7'd1;
        end
        if (blue) adj_rows[fill_row][fill_col[5:0]] = 1'b1;
        else adj_rows[fill_col[5:0]][fill_row] = 1'b1;
        fill_col++;
        if (fill_col >= n) begin
            fill_row++;
            fill_col = {1'b0, fill_row} + 7'd1;
        end
        complete = (fill_row >= n - 1);
        acyclic = 1'b1;
        if (!complete) return;
        found = 1'b0;
        for (int i = 0; i < MAX_V; i++) colour[i] = MARK_WHITE;
        for (root = 0; root < n && !found; root++) begin
            if (colour[root] != MARK_WHITE) continue;
            colour[root] = MARK_GREY;
            probe[root] = '0;
            trail[0] = root[5:0];
            depth = 1;
            while (depth > 0 && !found) begin
                v = trail[depth-1];
                c = probe[v];
                if (c >= n) begin
                    colour[v] = MARK_BLACK;
                    depth--;
                    continue;
                end
                probe[v] = c + 7'd1;
                if (!adj_rows[v][c[5:0]]) continue;
                if (colour[c[5:0]] == MARK_GREY) begin
                    found = 1'b1;
                end else if (colour[c[5:0]] == MARK_WHITE && depth < MAX_V) begin
                    colour[c[5:0]] = MARK_GREY;
                    probe[c[5:0]] = '0;
                    trail[depth] = c[5:0];
                    depth++;
                end
            end
        end
        acyclic = !found;
        if (n > widest_graph) widest_graph = n;
        clear_fill();
    endfunction

    task automatic send_pair(input logic blue, input logic typed, input logic want);
        logic complete;
        logic acyclic;
        if (idle_enabled && $urandom_range(0, 4) == 0) begin
            edge_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        edge_ch.valid <= 1'b1;
        edge_ch.edge_blue <= blue;
        @(posedge i_clk);
        while (!edge_ch.ready) @(posedge i_clk);
        predict_pair(blue, complete, acyclic);
        pairs_sent++;
        last_completed = complete;
        if (complete) begin
            graphs_sent++;
            if (acyclic) acyclic_graphs++;
            acyclic_q = {acyclic_q, (typed ? want : acyclic)};
        end
    endtask

    // block must be idle before a register write
    task automatic settle_block();
        int unsigned n;
        n = effective_vertices();
        edge_ch.valid <= 1'b0;
        while (acyclic_q.size() != 0) @(posedge i_clk);
        repeat (last_completed ? 4 * n + 16 : 8 * n * n + 64) @(posedge i_clk);
    endtask

    task automatic write_and_check(input logic [ADDR_W-1:0] addr,
                                   input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_VERTEX_COUNT) begin
            model_vc = data[VC_W-1:0];
            clear_fill();
        end
        cfg_writes++;
        // read back vertex_count
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_VERTEX_COUNT;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[VC_W-1:0] !== model_vc)
            flag_error($sformatf("vertex_count readback: expected %0d got %0d",
                                 model_vc, prdata[VC_W-1:0]));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: check, random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (acyclic_q.size() == 0) begin
                flag_error($sformatf("acyclic=%0d with no graph pending", res_ch.acyclic));
            end else begin
                want = acyclic_q.pop_front();
                results_seen++;
                if (res_ch.acyclic !== want)
                    flag_error($sformatf("acyclic: expected %0d got %0d",
                                         want, res_ch.acyclic));
            end
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            res_ch.ready <= 1'b0;
        end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
            rx_stall = $urandom_range(0, 14);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (edge_ch.valid && edge_ch.ready) || (res_ch.valid && res_ch.ready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a request", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned r;
        int unsigned phase;
        int unsigned vc;
        int unsigned graph_cnt;
        int unsigned g;
        int unsigned k;
        int unsigned a;
        int unsigned b;
        int unsigned idx;
        int unsigned t;
        int unsigned n;
        int unsigned style;
        int unsigned order [MAX_V];
        int unsigned rank_of [MAX_V];
        logic partial;
        logic pair_bits [$];
        logic [DATA_W-1:0] wdata;

        i_rst_n = 1'b0;
        edge_ch.valid = 1'b0;
        edge_ch.edge_blue = 1'b0;
        res_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        model_vc = VC_RESET;
        clear_fill();

        directed_rows = '{
            // two vertices after reset, one pair per graph
            '{ROW_PAIR,         32'd1,         1'b1, 1'b1},
            '{ROW_PAIR,         32'd0,         1'b1, 1'b1},
            '{ROW_SET_REG,      32'd3,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd0,         1'b0, 1'b0},
            // 0->1, 2->0, 1->2: a directed cycle through all three vertices
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd0,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b1, 1'b0},
            // below range clamps to two
            '{ROW_SET_REG,      32'd0,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd0,         1'b1, 1'b1},
            '{ROW_SET_REG,      32'hFFFF_FF81, 1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b1, 1'b1},
            '{ROW_SET_UNMAPPED, 32'd5,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd0,         1'b1, 1'b1},
            // partial load, then a rewrite restarts it
            '{ROW_SET_REG,      32'd4,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd0,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0},
            '{ROW_SET_REG,      32'h7FFF_FF04, 1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b1, 1'b1},
            // above range clamps to the maximum
            '{ROW_SET_REG,      32'd127,       1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd0,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0},
            '{ROW_PAIR,         32'd0,         1'b0, 1'b0},
            '{ROW_SET_REG,      32'd64,        1'b0, 1'b0},
            '{ROW_PAIR,         32'd1,         1'b0, 1'b0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DIRECTED_LEN; r++) begin
            case (directed_rows[r].kind)
                ROW_PAIR: begin
                    send_pair(directed_rows[r].value[0], directed_rows[r].typed,
                              directed_rows[r].want);
                end
                ROW_SET_REG: begin
                    settle_block();
                    write_and_check(ADDR_VERTEX_COUNT, directed_rows[r].value);
                end
                default: begin
                    settle_block();
                    write_and_check(ADDR_UNMAPPED, directed_rows[r].value);
                end
            endcase
        end

        phase = 0;
        while (pairs_sent < ITEM_GOAL) begin
            idle_enabled = (pairs_sent < ITEM_GOAL * 4 / 5) && (phase % 4 != 3);
            r = $urandom_range(0, 9);
            partial = 1'b0;
            graph_cnt = $urandom_range(1, 4);
            vc = $urandom_range(3, 9);
            if (phase == 2) begin
                vc = 3;
                graph_cnt = 12;
            end else if (phase == 5) begin
                vc = 16;
                graph_cnt = 1;
            end else if (r == 0 && idle_enabled) begin
                vc = $urandom_range(64, 127);
                partial = 1'b1;
            end else if (r == 1) begin
                vc = $urandom_range(0, 2);
                graph_cnt = $urandom_range(3, 6);
            end
            settle_block();
            wdata = $urandom();
            wdata[VC_W-1:0] = vc[VC_W-1:0];
            write_and_check(ADDR_VERTEX_COUNT, wdata);
            n = effective_vertices();
            if (phase == 2) hold_request = PRESSURE_HOLD;
            if (partial) begin
                for (k = $urandom_range(1, 30); k > 0; k--)
                    send_pair(1'($urandom_range(0, 1)), 1'b0, 1'b0);
            end else begin
                for (g = 0; g < graph_cnt; g++) begin
                    for (k = 0; k < n; k++) order[k] = k;
                    for (k = n - 1; k > 0; k--) begin
                        idx = $urandom_range(0, k);
                        t = order[k];
                        order[k] = order[idx];
                        order[idx] = t;
                    end
                    for (k = 0; k < n; k++) rank_of[order[k]] = k;
                    // mostly ranked orders (acyclic), some with one edge flipped, some random, some one colour
                    style = (phase == 5) ? 0 : $urandom_range(0, 19);
                    pair_bits.delete();
                    for (a = 0; a < n - 1; a++) begin
                        for (b = a + 1; b < n; b++) begin
                            if (style < 13)
                                pair_bits = {pair_bits, (rank_of[a] < rank_of[b])};
                            else if (style < 18)
                                pair_bits = {pair_bits, 1'($urandom_range(0, 1))};
                            else
                                pair_bits = {pair_bits, (style == 18)};
                        end
                    end
                    if (style >= 8 && style < 13) begin
                        idx = $urandom_range(0, pair_bits.size() - 1);
                        pair_bits[idx] = !pair_bits[idx];
                    end
                    for (k = 0; k < pair_bits.size(); k++)
                        send_pair(pair_bits[k], 1'b0, 1'b0);
                end
            end
            phase++;
        end

        edge_ch.valid <= 1'b0;
        while (acyclic_q.size() != 0) @(posedge i_clk);
        repeat (4 * effective_vertices() + 32) @(posedge i_clk);
        $display("covered %0d pairs, %0d graphs (%0d acyclic), %0d results, %0d reg writes",
                 pairs_sent, graphs_sent, acyclic_graphs, results_seen, cfg_writes);
        $display("graphs up to %0d vertices, one %0d-cycle hold on the result side",
                 widest_graph, PRESSURE_HOLD);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
